// File: rtl/core/mcf_pkg.sv
// Shared constants, codes and control types of the metafile command framer.
package mcf_pkg;

    // Default partition buffer depth and short-form length limit
    localparam int PART_BYTES_DEF  = 32;
    localparam int SHORT_LIMIT_DEF = 30;

    // Header length code that marks the long form
    localparam logic [4:0] LONG_FORM_CODE = 5'd31;
    // Continuation flag in the high byte of the length word
    localparam logic [7:0] CONT_FLAG = 8'h80;

    // Request kinds carried in tuser
    typedef logic [1:0] req_kind_t;
    localparam req_kind_t REQ_START = 2'd0;
    localparam req_kind_t REQ_DATA  = 2'd1;
    localparam req_kind_t REQ_END   = 2'd2;

    // Selector of the byte loaded into the output register
    typedef logic [2:0] byte_sel_t;
    localparam byte_sel_t SEL_HDR0 = 3'd0;
    localparam byte_sel_t SEL_HDR1 = 3'd1;
    localparam byte_sel_t SEL_LEN0 = 3'd2;
    localparam byte_sel_t SEL_LEN1 = 3'd3;
    localparam byte_sel_t SEL_DATA = 3'd4;
    localparam byte_sel_t SEL_PAD  = 3'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      accept;      // input transfer may complete
        logic      start_cmd;   // open a new command
        logic      store_byte;  // write the input byte into the buffer
        logic      close_cmd;   // mark the command closed
        logic      emit_load;   // load one byte into the output register
        byte_sel_t emit_sel;    // which byte to load
        logic      emit_last;   // byte is the last of this run
        logic      short_form;  // header byte 1 carries the length
        logic      final_part;  // partition ends the command
        logic      read_first;  // fetch buffer entry zero
        logic      read_next;   // fetch the following buffer entry
        logic      finish;      // partition done: restart the count and clear the first flag
    } mcf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic      in_valid;
        req_kind_t in_kind;
        logic      cmd_open;
        logic      buf_full;
        logic      len_zero;
        logic      len_odd;
        logic      idx_last;
        logic      first_part;
        logic      short_fit;
        logic      slot_free;
    } mcf_status_t;

endpackage

// File: rtl/core/metafile_command_framer_unit.sv
// Top level of the metafile command framer: stream ports, controller and datapath.
//
// Frames binary metafile commands into a byte stream. A start transfer opens a
// command, data transfers fill a partition buffer of PART_BYTES entries, and an
// end transfer flushes it as the final partition. A transfer that emits a
// partition is accepted and then followed by its stream bytes (header, length
// word, data, pad), one byte per cycle while the output register has a free
// slot; the registered buffer read is fetched one entry ahead so data bytes
// leave back to back. No new input is taken until the last byte of a partition
// is loaded into the output register. An overflowing byte is held and written
// to the buffer when the last byte of the full partition has been loaded.
module metafile_command_framer_unit
    import mcf_pkg::*;
#(
    parameter int PART_BYTES  = PART_BYTES_DEF,
    parameter int SHORT_LIMIT = SHORT_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] class_code, [10:4] element_id, [18:11] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // run_last
);

    mcf_cmd_t    cmd;
    mcf_status_t status;

    mcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    mcf_datapath #(
        .PART_BYTES  (PART_BYTES),
        .SHORT_LIMIT (SHORT_LIMIT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_kind       (s_tuser),
        .s_class_code (s_tdata[3:0]),
        .s_element_id (s_tdata[10:4]),
        .s_data_byte  (s_tdata[18:11]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_out_byte   (m_tdata),
        .m_run_last   (m_tlast),
        .cmd          (cmd),
        .status       (status)
    );

    // Input side is ready while the controller waits for a request
    assign s_tready = cmd.accept;

endmodule

// File: rtl/core/mcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mcf_ram
    import mcf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = PART_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while idle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mcf_ctrl.sv
// Controller state machine that sequences command framing and byte emission.
module mcf_ctrl
    import mcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mcf_status_t status,
    output mcf_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR0 = 3'd1;
    localparam logic [2:0] ST_HDR1 = 3'd2;
    localparam logic [2:0] ST_LEN0 = 3'd3;
    localparam logic [2:0] ST_LEN1 = 3'd4;
    localparam logic [2:0] ST_DATA = 3'd5;
    localparam logic [2:0] ST_PAD  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       final_reg, final_next;
    logic       short_sel;
    logic       take;

    assign short_sel = final_reg && status.short_fit;
    assign take      = status.in_valid && (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next     = state_reg;
        final_next     = final_reg;
        cmd            = '0;
        cmd.final_part = final_reg;
        cmd.short_form = short_sel;
        cmd.emit_sel   = SEL_HDR0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = 1'b1;
                if (take) begin
                    unique case (status.in_kind)
                        REQ_START: begin
                            cmd.start_cmd = 1'b1;
                        end
                        REQ_DATA: begin
                            if (status.cmd_open) begin
                                if (!status.buf_full) begin
                                    cmd.store_byte = 1'b1;
                                end else begin
                                    final_next = 1'b0;
                                    state_next = status.first_part ? ST_HDR0 : ST_LEN0;
                                end
                            end
                        end
                        REQ_END: begin
                            if (status.cmd_open) begin
                                cmd.close_cmd = 1'b1;
                                final_next    = 1'b1;
                                state_next    = status.first_part ? ST_HDR0 : ST_LEN0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_HDR0: begin
                cmd.emit_sel = SEL_HDR0;
                if (status.slot_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_HDR1;
                end
            end
            ST_HDR1: begin
                cmd.emit_sel = SEL_HDR1;
                if (status.slot_free) begin
                    cmd.emit_load = 1'b1;
                    if (!short_sel) begin
                        state_next = ST_LEN0;
                    end else if (status.len_zero) begin
                        cmd.emit_last = 1'b1;
                        cmd.finish    = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.read_first = 1'b1;
                        state_next     = ST_DATA;
                    end
                end
            end
            ST_LEN0: begin
                cmd.emit_sel = SEL_LEN0;
                if (status.slot_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_LEN1;
                end
            end
            ST_LEN1: begin
                cmd.emit_sel = SEL_LEN1;
                if (status.slot_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.len_zero) begin
                        cmd.emit_last = 1'b1;
                        cmd.finish    = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.read_first = 1'b1;
                        state_next     = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                cmd.emit_sel = SEL_DATA;
                if (status.slot_free) begin
                    cmd.emit_load = 1'b1;
                    if (!status.idx_last) begin
                        cmd.read_next = 1'b1;
                    end else if (status.len_odd) begin
                        state_next = ST_PAD;
                    end else begin
                        cmd.emit_last = 1'b1;
                        cmd.finish    = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                cmd.emit_sel = SEL_PAD;
                if (status.slot_free) begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.finish    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and partition kind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

endmodule

// File: rtl/core/mcf_datapath.sv
// Datapath: command registers, partition buffer, byte selection and output register.
module mcf_datapath
    import mcf_pkg::*;
#(
    parameter int PART_BYTES  = PART_BYTES_DEF,
    parameter int SHORT_LIMIT = SHORT_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  req_kind_t   s_kind,
    input  logic [3:0]  s_class_code,
    input  logic [6:0]  s_element_id,
    input  logic [7:0]  s_data_byte,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    input  mcf_cmd_t    cmd,
    output mcf_status_t status
);

    localparam int CNT_W  = $clog2(PART_BYTES + 1);
    localparam int ADDR_W = $clog2(PART_BYTES);

    logic [3:0]        class_reg;
    logic [6:0]        element_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              first_reg;
    logic              open_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [7:0]        pend_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic              in_take;
    logic              slot_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        byte_sel_val;
    logic [7:0]        hdr1_base;

    assign in_take   = s_tvalid && cmd.accept;
    assign slot_free = !out_valid_reg || m_tready;
    assign hdr1_base = {element_reg[2:0], 5'b0};

    // Report status to the controller
    always_comb begin
        status            = '0;
        status.in_valid   = s_tvalid;
        status.in_kind    = s_kind;
        status.cmd_open   = open_reg;
        status.buf_full   = (count_reg == CNT_W'(PART_BYTES));
        status.len_zero   = (count_reg == '0);
        status.len_odd    = count_reg[0];
        status.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        status.first_part = first_reg;
        status.short_fit  = (8'(count_reg) <= 8'(SHORT_LIMIT));
        status.slot_free  = slot_free;
    end

    // Buffer writes: data bytes on transfer, held byte after an overflow partition
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = s_data_byte;
        if (cmd.store_byte) begin
            ram_we = 1'b1;
        end else if (cmd.finish && !cmd.final_part) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = pend_reg;
        end
    end

    // Buffer reads one entry ahead of the output register
    assign ram_re    = cmd.read_first || cmd.read_next;
    assign ram_raddr = cmd.read_first ? '0 : ADDR_W'(idx_reg + 1'b1);

    mcf_ram #(
        .WIDTH (8),
        .DEPTH (PART_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Select the stream byte
    always_comb begin
        unique case (cmd.emit_sel)
            SEL_HDR0: byte_sel_val = {class_reg, element_reg[6:3]};
            SEL_HDR1: byte_sel_val = cmd.short_form ? (hdr1_base | 8'(count_reg))
                                                    : (hdr1_base | 8'(LONG_FORM_CODE));
            SEL_LEN0: byte_sel_val = cmd.final_part ? 8'h00 : CONT_FLAG;
            SEL_LEN1: byte_sel_val = 8'(count_reg);
            SEL_DATA: byte_sel_val = ram_rdata;
            default:  byte_sel_val = 8'h00;
        endcase
    end

    // Command state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg   <= '0;
            element_reg <= '0;
            count_reg   <= '0;
            first_reg   <= 1'b1;
            open_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (cmd.start_cmd) begin
                class_reg   <= s_class_code;
                element_reg <= s_element_id;
                count_reg   <= '0;
                first_reg   <= 1'b1;
                open_reg    <= 1'b1;
            end
            if (cmd.store_byte) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.close_cmd) begin
                open_reg <= 1'b0;
            end
            if (cmd.read_first) begin
                idx_reg <= '0;
            end else if (cmd.read_next) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.finish) begin
                first_reg <= 1'b0;
                count_reg <= cmd.final_part ? '0 : CNT_W'(1);
            end
        end
    end

    // Capture each taken data byte; kept for the byte that overflowed a full buffer
    always_ff @(posedge aclk) begin
        if (in_take) begin
            pend_reg <= s_data_byte;
        end
    end

    // Output register: load on emit, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_byte_reg <= byte_sel_val;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_run_last = out_last_reg;

endmodule

// File: tb/metafile_command_framer_unit_tb.sv
// Self-checking testbench for the metafile command framer: directed and random stream traffic vs. a predictor.
module metafile_command_framer_unit_tb;
    import mcf_pkg::*;

    localparam int PART_BYTES  = PART_BYTES_DEF;
    localparam int SHORT_LIMIT = SHORT_LIMIT_DEF;
    // Idle-cycle count with no transfer on either side that ends the run
    localparam int IDLE_LIMIT  = 2000;
    // Cycles allowed after the last expected byte for any stray output
    localparam int TAIL_CYCLES = 80;
    // Request code the block must ignore
    localparam req_kind_t REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } stream_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [3:0] class_code, [10:4] element_id, [18:11] data_byte
    logic [1:0]  s_tuser  = '0;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] out_byte
    logic        m_tlast;         // run_last

    // Predictor state: partition buffer and open command
    logic [7:0]  part_buf [PART_BYTES];
    int unsigned part_fill;
    logic [3:0]  open_class;
    logic [6:0]  open_elem;
    bit          first_part;
    bit          cmd_is_open;

    stream_byte_t expected_stream[$];
    int           fail_count  = 0;
    int           idle_cycles = 0;
    int           items_sent  = 0;
    int           idle_pct    = 30;
    int           ready_left  = 0;

    metafile_command_framer_unit #(
        .PART_BYTES  (PART_BYTES),
        .SHORT_LIMIT (SHORT_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (idle_pct == 0 || r >= idle_pct) begin
            return 0;
        end else if (r < 3) begin
            return $urandom_range(20, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void push_stream_byte(logic [7:0] b);
        expected_stream.push_back('{val: b, last: 1'b0});
    endfunction

    // Emit the buffered bytes as one partition of the framed stream
    function automatic void emit_partition(bit final_part);
        logic [7:0] hdr0;
        logic [7:0] hdr1;
        int         idx;
        hdr0 = {open_class, open_elem[6:3]};
        hdr1 = {open_elem[2:0], 5'b0};
        if (final_part && first_part && part_fill <= SHORT_LIMIT) begin
            push_stream_byte(hdr0);
            push_stream_byte(hdr1 | 8'(part_fill));
        end else begin
            if (first_part) begin
                push_stream_byte(hdr0);
                push_stream_byte(hdr1 | {3'b0, LONG_FORM_CODE});
            end
            // length word, high byte first, continuation flag on non-final parts
            push_stream_byte((final_part ? 8'h00 : CONT_FLAG) | 8'((part_fill >> 8) & 127));
            push_stream_byte(8'(part_fill));
        end
        for (idx = 0; idx < int'(part_fill); idx++) begin
            push_stream_byte(part_buf[idx]);
        end
        if (part_fill[0]) begin
            push_stream_byte(8'h00);
        end
        expected_stream[expected_stream.size() - 1].last = 1'b1;
        part_fill  = 0;
        first_part = 1'b0;
    endfunction

    // Advance the predictor by one accepted request
    function automatic void frame_request(req_kind_t kind, logic [23:0] data);
        case (kind)
            REQ_START: begin
                open_class  = data[3:0];
                open_elem   = data[10:4];
                part_fill   = 0;
                first_part  = 1'b1;
                cmd_is_open = 1'b1;
            end
            REQ_DATA: begin
                if (cmd_is_open) begin
                    if (part_fill >= PART_BYTES) begin
                        emit_partition(1'b0);
                    end
                    part_buf[part_fill] = data[18:11];
                    part_fill++;
                end
            end
            REQ_END: begin
                if (cmd_is_open) begin
                    emit_partition(1'b1);
                    cmd_is_open = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // Predict on input transfers, check output transfers, watch for a hang
    always @(posedge aclk) begin
        stream_byte_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                frame_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_stream.size() == 0) begin
                    note_failure($sformatf("byte %02h last %0b with nothing expected",
                                           m_tdata, m_tlast));
                end else begin
                    want = expected_stream.pop_front();
                    if (m_tdata !== want.val) begin
                        note_failure($sformatf("out_byte expected %02h actual %02h",
                                               want.val, m_tdata));
                    end
                    if (m_tlast !== want.last) begin
                        note_failure($sformatf("run_last expected %0b actual %0b",
                                               want.last, m_tlast));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: ready stretches and stalls of random length
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left--;
        end else if (idle_pct == 0 || $urandom_range(99) >= idle_pct) begin
            m_tready   <= 1'b1;
            ready_left = $urandom_range(0, 6);
        end else begin
            m_tready   <= 1'b0;
            ready_left = pick_idle();
        end
    end

    // Send one request; valid stays high afterwards for a back-to-back transfer
    task automatic send_item(req_kind_t kind, logic [3:0] cls, logic [6:0] elem,
                             logic [7:0] dbyte);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, dbyte, elem, cls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic hold_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending until every expected byte has come out
    task automatic wait_drained();
        hold_input();
        while (expected_stream.size() != 0) @(posedge aclk);
    endtask

    // One command with random header and content; close selects the end request
    task automatic send_command(int n_bytes, bit close);
        send_item(REQ_START, 4'($urandom), 7'($urandom), 8'($urandom));
        repeat (n_bytes) send_item(REQ_DATA, 4'($urandom), 7'($urandom), 8'($urandom));
        if (close) begin
            send_item(REQ_END, 4'($urandom), 7'($urandom), 8'($urandom));
        end
    endtask

    task automatic apply_reset();
        part_fill   = 0;
        open_class  = '0;
        open_elem   = '0;
        first_part  = 1'b1;
        cmd_is_open = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    endtask

    // Field extremes, every request kind and the ignore/discard cases
    task automatic test_directed_cases();
        // drop data and end outside a command, ignore the unused code
        send_item(REQ_DATA, 4'hF, 7'h7F, 8'hFF);
        send_item(REQ_END, 4'h0, 7'h00, 8'h00);
        send_item(REQ_UNUSED, 4'hF, 7'h7F, 8'hFF);
        // empty command at the top class and element
        send_item(REQ_START, 4'hF, 7'h7F, 8'hFF);
        send_item(REQ_END, 4'hF, 7'h7F, 8'hFF);
        // odd length gets a pad byte
        send_item(REQ_START, 4'h0, 7'h00, 8'h00);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'h00);
        send_item(REQ_END, 4'h0, 7'h00, 8'h00);
        send_item(REQ_START, 4'hA, 7'h55, 8'h00);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'hFF);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'h00);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'hA5);
        send_item(REQ_END, 4'h0, 7'h00, 8'h00);
        // restart discards the open command and its bytes
        send_item(REQ_START, 4'h3, 7'h2A, 8'h00);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'h01);
        send_item(REQ_START, 4'h5, 7'h09, 8'h00);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'h77);
        send_item(REQ_END, 4'h0, 7'h00, 8'h00);
        // unused code inside an open command changes nothing
        send_item(REQ_START, 4'h6, 7'h31, 8'h00);
        send_item(REQ_UNUSED, 4'h0, 7'h00, 8'h00);
        send_item(REQ_DATA, 4'h0, 7'h00, 8'h3C);
        send_item(REQ_END, 4'h0, 7'h00, 8'h00);
        send_item(REQ_END, 4'h0, 7'h00, 8'h00);
    endtask

    // Lengths around the short limit and past the buffer size, overflow included
    task automatic test_partition_lengths();
        int lengths[3] = '{SHORT_LIMIT, SHORT_LIMIT + 1, PART_BYTES + 1};
        foreach (lengths[i]) begin
            send_command(lengths[i], 1'b1);
        end
        wait_drained();
    endtask

    // Mostly well-formed commands, some noise, broken commands and a no-idle stretch
    task automatic test_random_traffic();
        int first_item;
        int r;
        int n_bytes;
        first_item = items_sent;
        while (items_sent - first_item < 60) begin
            if (items_sent - first_item >= 20 && items_sent - first_item < 40) begin
                idle_pct = 0;
            end else begin
                idle_pct = 30;
            end
            r = $urandom_range(99);
            if (r < 8) begin
                send_item(req_kind_t'($urandom_range(3)), 4'($urandom), 7'($urandom),
                          8'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    n_bytes = $urandom_range(0, 12);
                end else if (r < 92) begin
                    n_bytes = $urandom_range(13, 34);
                end else begin
                    n_bytes = $urandom_range(35, 70);
                end
                send_command(n_bytes, $urandom_range(9) != 0);
            end
            if ($urandom_range(19) == 0) begin
                wait_drained();
            end
        end
        idle_pct = 30;
    endtask

    initial begin
        apply_reset();
        test_directed_cases();
        wait_drained();
        test_partition_lengths();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mcf_pkg.sv
rtl/core/mcf_ram.sv
rtl/core/mcf_ctrl.sv
rtl/core/mcf_datapath.sv
rtl/core/metafile_command_framer_unit.sv
tb/metafile_command_framer_unit_tb.sv
